>>> hw/rtl/rsbcm_pkg.sv
// Shared types and constants for the read-structure base-count matrix.
// Holds the queue entry type, the base decoder and the segment codes.
// No dependencies.
package rsbcm_pkg;

    localparam int NUM_REGS    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 10;
    localparam int SEG_IDX_W   = 4;
    localparam int SEG_SEL_W   = 3;
    localparam int SEG_LEN_W   = 8;
    localparam int SIZE_W      = 7;
    localparam int POS_W       = 6;
    localparam int QPOS_W      = 5;
    localparam int CODE_W      = 3;
    localparam int NUM_BASES   = 5;
    localparam int OUT_CNT_W   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0] SEG_BARCODE = 2'd0;
    localparam logic [1:0] SEG_UMI     = 2'd1;

    localparam logic [CODE_W-1:0] BASE_A = 3'd0;
    localparam logic [CODE_W-1:0] BASE_C = 3'd1;
    localparam logic [CODE_W-1:0] BASE_G = 3'd2;
    localparam logic [CODE_W-1:0] BASE_T = 3'd3;
    localparam logic [CODE_W-1:0] BASE_N = 3'd4;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
    } t_base;

    typedef struct packed {
        logic              is_query;
        logic              is_umi;
        logic [POS_W-1:0]  pos;
        logic [CODE_W-1:0] code;
        logic              pos_ok;
    } t_op;

    function automatic t_base decode_base(input logic [7:0] ch);
        t_base b;
        b.ok = 1'b1;
        unique case (ch) inside
            8'h41, 8'h61: b.code = BASE_A;
            8'h43, 8'h63: b.code = BASE_C;
            8'h47, 8'h67: b.code = BASE_G;
            8'h54, 8'h74: b.code = BASE_T;
            8'h4E, 8'h6E: b.code = BASE_N;
            default: begin
                b.ok   = 1'b0;
                b.code = BASE_A;
            end
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/read_structure_base_count_matrix.sv
// Read-structure base-count matrix, top level: front, queue and back.
// Throughput: one item per cycle while the queue has room; a held output stalls
// queries. Each base is one counter row read-modify-write on separate read and
// write ports, with a bypass for back-to-back updates of the same row.
// Reset (synchronous, active low) clears all counts at once through per-row
// valid bits, so no clearing pass is needed and items are taken straight away.
module read_structure_base_count_matrix
    import rsbcm_pkg::*;
#(
    parameter int MAX_BARCODE_LEN = 32,
    parameter int MAX_UMI_LEN     = 16,
    parameter int NUM_SEGMENTS    = 8,
    parameter int COUNT_WIDTH     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // base_char [7:0], query_position [12:8], zero [15:13]
    input  logic [15:0]                    i_s_tdata,
    // req_type [0], matrix_select [1]
    input  logic [1:0]                     i_s_tuser,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // count_a [31:0], count_c [63:32], count_g [95:64], count_t [127:96],
    // count_n [159:128]
    output logic [NUM_BASES*OUT_CNT_W-1:0] o_m_tdata,
    // position_ok [0]
    output logic                           o_m_tuser
);

    logic f_op_valid, f_op_ready, q_op_valid, q_op_ready;
    t_op  f_op, q_op;

    assign o_cfg_ready = 1'b1;

    rsbcm_front #(
        .MAX_BARCODE_LEN (MAX_BARCODE_LEN),
        .MAX_UMI_LEN     (MAX_UMI_LEN),
        .NUM_SEGMENTS    (NUM_SEGMENTS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_req_type       (i_s_tuser[0]),
        .i_base_char      (i_s_tdata[7:0]),
        .i_end_of_read    (i_s_tlast),
        .i_matrix_select  (i_s_tuser[1]),
        .i_query_position (i_s_tdata[12:8]),
        .o_op_valid       (f_op_valid),
        .i_op_ready       (f_op_ready),
        .o_op             (f_op)
    );

    rsbcm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_op_valid),
        .o_push_ready (f_op_ready),
        .i_push_op    (f_op),
        .o_pop_valid  (q_op_valid),
        .i_pop_ready  (q_op_ready),
        .o_pop_op     (q_op)
    );

    rsbcm_back #(
        .MAX_BARCODE_LEN (MAX_BARCODE_LEN),
        .MAX_UMI_LEN     (MAX_UMI_LEN),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (q_op_valid),
        .o_op_ready    (q_op_ready),
        .i_op          (q_op),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_counts      (o_m_tdata),
        .o_position_ok (o_m_tuser)
    );

endmodule

>>> hw/rtl/rsbcm_front.sv
// Front end: holds the segment registers, walks the read structure and
// turns each accepted query into a count query and each accepted valid base at a
// counted position into a counter update. Depends on rsbcm_pkg.
module rsbcm_front
    import rsbcm_pkg::*;
#(
    parameter int MAX_BARCODE_LEN = 32,
    parameter int MAX_UMI_LEN     = 16,
    parameter int NUM_SEGMENTS    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_req_type,
    input  logic [7:0]            i_base_char,
    input  logic                  i_end_of_read,
    input  logic                  i_matrix_select,
    input  logic [QPOS_W-1:0]     i_query_position,
    output logic                  o_op_valid,
    input  logic                  i_op_ready,
    output t_op                   o_op
);

    localparam int BC_POS_W  = $clog2(MAX_BARCODE_LEN + 1);
    localparam int UMI_POS_W = $clog2(MAX_UMI_LEN + 1);
    localparam int SUM_W     = SEG_LEN_W + 3;

    logic [CFG_DATA_W-1:0] r_seg [NUM_REGS];
    logic [SIZE_W-1:0]     r_bc_size, r_umi_size;
    logic [SIZE_W-1:0]     n_bc_size, n_umi_size;
    logic [SEG_IDX_W-1:0]  r_seg_idx, n_seg_idx;
    logic [SEG_LEN_W-1:0]  r_off, n_off;
    logic [BC_POS_W-1:0]   r_bc_pos, n_bc_pos;
    logic [UMI_POS_W-1:0]  r_umi_pos, n_umi_pos;

    logic [SUM_W-1:0]      sum_bc, sum_umi;
    logic                  seg_found;
    logic [SEG_SEL_W-1:0]  seg_sel;
    logic [SEG_LEN_W-1:0]  eff_off;
    logic [SEG_LEN_W:0]    off_inc;
    logic [1:0]            sel_type;
    logic                  accept;
    logic                  bump;
    t_base                 base;
    t_op                   op;

    // The matrix sizes follow the segment registers including a write in
    // this cycle, so a query right after a write sees the new sizes.
    always_comb begin
        logic [CFG_DATA_W-1:0] seg_w;
        sum_bc  = '0;
        sum_umi = '0;
        for (int k = 0; k < NUM_SEGMENTS; k++) begin
            seg_w = (i_cfg_valid && i_cfg_index == CFG_IDX_W'(k)) ? i_cfg_data : r_seg[k];
            if (seg_w[9:8] == SEG_BARCODE) begin
                sum_bc = sum_bc + SUM_W'(seg_w[SEG_LEN_W-1:0]);
            end
            if (seg_w[9:8] == SEG_UMI) begin
                sum_umi = sum_umi + SUM_W'(seg_w[SEG_LEN_W-1:0]);
            end
        end
        n_bc_size  = (sum_bc >= SUM_W'(MAX_BARCODE_LEN)) ? SIZE_W'(MAX_BARCODE_LEN)
                                                         : SIZE_W'(sum_bc);
        n_umi_size = (sum_umi >= SUM_W'(MAX_UMI_LEN)) ? SIZE_W'(MAX_UMI_LEN)
                                                      : SIZE_W'(sum_umi);
    end

    always_comb begin
        seg_found = 1'b0;
        seg_sel   = '0;
        for (int k = 0; k < NUM_SEGMENTS; k++) begin
            if (!seg_found && SEG_IDX_W'(k) >= r_seg_idx) begin
                if (SEG_IDX_W'(k) == r_seg_idx) begin
                    if (r_off < r_seg[k][SEG_LEN_W-1:0]) begin
                        seg_found = 1'b1;
                        seg_sel   = SEG_SEL_W'(k);
                    end
                end else if (r_seg[k][SEG_LEN_W-1:0] != '0) begin
                    seg_found = 1'b1;
                    seg_sel   = SEG_SEL_W'(k);
                end
            end
        end
        eff_off  = ({1'b0, seg_sel} == r_seg_idx) ? r_off : '0;
        off_inc  = {1'b0, eff_off} + 1'b1;
        sel_type = r_seg[seg_sel][9:8];
    end

    assign base   = decode_base(i_base_char);
    assign accept = i_valid && o_ready;

    always_comb begin
        n_seg_idx = r_seg_idx;
        n_off     = r_off;
        n_bc_pos  = r_bc_pos;
        n_umi_pos = r_umi_pos;
        bump      = 1'b0;
        op        = '0;
        if (i_req_type) begin
            op.is_query = 1'b1;
            op.is_umi   = i_matrix_select;
            op.pos      = POS_W'(i_query_position);
            op.pos_ok   = i_matrix_select
                        ? (SIZE_W'(i_query_position) < r_umi_size)
                        : (SIZE_W'(i_query_position) < r_bc_size);
        end else begin
            op.code = base.code;
            if (seg_found) begin
                if (sel_type == SEG_BARCODE && r_bc_pos < BC_POS_W'(MAX_BARCODE_LEN)) begin
                    bump     = base.ok;
                    op.pos   = POS_W'(r_bc_pos);
                    n_bc_pos = r_bc_pos + 1'b1;
                end else if (sel_type == SEG_UMI &&
                             r_umi_pos < UMI_POS_W'(MAX_UMI_LEN)) begin
                    bump      = base.ok;
                    op.is_umi = 1'b1;
                    op.pos    = POS_W'(r_umi_pos);
                    n_umi_pos = r_umi_pos + 1'b1;
                end
                if (off_inc >= {1'b0, r_seg[seg_sel][SEG_LEN_W-1:0]}) begin
                    n_seg_idx = {1'b0, seg_sel} + 1'b1;
                    n_off     = '0;
                end else begin
                    n_seg_idx = {1'b0, seg_sel};
                    n_off     = off_inc[SEG_LEN_W-1:0];
                end
            end else begin
                n_seg_idx = SEG_IDX_W'(NUM_SEGMENTS);
                n_off     = '0;
            end
            if (i_end_of_read) begin
                n_seg_idx = '0;
                n_off     = '0;
                n_bc_pos  = '0;
                n_umi_pos = '0;
            end
        end
    end

    assign o_ready    = i_op_ready;
    assign o_op_valid = i_valid && (i_req_type || bump);
    assign o_op       = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_seg[k] <= '0;
            end
            r_bc_size  <= '0;
            r_umi_size <= '0;
            r_seg_idx  <= '0;
            r_off      <= '0;
            r_bc_pos   <= '0;
            r_umi_pos  <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(NUM_REGS)) begin
                r_seg[i_cfg_index[SEG_SEL_W-1:0]] <= i_cfg_data;
            end
            r_bc_size  <= n_bc_size;
            r_umi_size <= n_umi_size;
            if (accept && !i_req_type) begin
                r_seg_idx <= n_seg_idx;
                r_off     <= n_off;
                r_bc_pos  <= n_bc_pos;
                r_umi_pos <= n_umi_pos;
            end
        end
    end

endmodule

>>> hw/rtl/rsbcm_queue.sv
// Short first-word-fall-through queue of operations between front and back.
// Ready depends on the fill count only.
// Depends on rsbcm_pkg.
module rsbcm_queue
    import rsbcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_op
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_push_ready = r_count < QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_op     = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/rsbcm_back.sv
// Back end: count memory with one row of five counters per position,
// read-modify-write with bypass, and the result output register.
// Depends on rsbcm_pkg.
module rsbcm_back
    import rsbcm_pkg::*;
#(
    parameter int MAX_BARCODE_LEN = 32,
    parameter int MAX_UMI_LEN     = 16,
    parameter int COUNT_WIDTH     = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_op_valid,
    output logic                            o_op_ready,
    input  t_op                             i_op,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [NUM_BASES*OUT_CNT_W-1:0]  o_counts,
    output logic                            o_position_ok
);

    localparam int ROWS     = MAX_BARCODE_LEN + MAX_UMI_LEN;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ROW_BITS = NUM_BASES * COUNT_WIDTH;

    logic [ROW_BITS-1:0]            r_mem [ROWS];
    logic [ROWS-1:0]                r_row_vld;
    logic                           r_s1_valid;
    t_op                            r_s1_op;
    logic [ROW_W-1:0]               r_s1_addr;
    logic [ROW_BITS-1:0]            r_rd_row;
    logic                           r_rd_vld;
    logic                           r_out_valid;
    logic [NUM_BASES*OUT_CNT_W-1:0] r_out_counts;
    logic                           r_out_pos_ok;

    logic                           out_free, s1_go, stage_free, issue, wr_en;
    logic [ROW_W-1:0]               iss_addr;
    logic [ROW_BITS-1:0]            row_cur, new_row;
    logic [NUM_BASES*OUT_CNT_W-1:0] q_counts;

    assign out_free   = !r_out_valid || i_ready;
    assign s1_go      = r_s1_valid && (!r_s1_op.is_query || out_free);
    assign stage_free = !r_s1_valid || s1_go;
    assign issue      = i_op_valid && stage_free;
    assign o_op_ready = stage_free;
    assign wr_en      = r_s1_valid && !r_s1_op.is_query;
    assign iss_addr   = i_op.is_umi ? ROW_W'(MAX_BARCODE_LEN) + ROW_W'(i_op.pos)
                                    : ROW_W'(i_op.pos);
    assign row_cur    = r_rd_vld ? r_rd_row : '0;

    always_comb begin
        logic [COUNT_WIDTH-1:0] cnt;
        new_row  = row_cur;
        q_counts = '0;
        for (int k = 0; k < NUM_BASES; k++) begin
            cnt = row_cur[k*COUNT_WIDTH +: COUNT_WIDTH];
            if (CODE_W'(k) == r_s1_op.code && cnt != '1) begin
                new_row[k*COUNT_WIDTH +: COUNT_WIDTH] = cnt + 1'b1;
            end
            if (r_s1_op.pos_ok) begin
                q_counts[k*OUT_CNT_W +: OUT_CNT_W] = OUT_CNT_W'(cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_addr] <= new_row;
        end
        if (issue) begin
            r_s1_op   <= i_op;
            r_s1_addr <= iss_addr;
            if (wr_en && r_s1_addr == iss_addr) begin
                r_rd_row <= new_row;
                r_rd_vld <= 1'b1;
            end else begin
                r_rd_row <= r_mem[iss_addr];
                r_rd_vld <= r_row_vld[iss_addr];
            end
        end
        if (s1_go && r_s1_op.is_query) begin
            r_out_counts <= q_counts;
            r_out_pos_ok <= r_s1_op.pos_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[r_s1_addr] <= 1'b1;
            end
            if (stage_free) begin
                r_s1_valid <= i_op_valid;
            end
            if (s1_go && r_s1_op.is_query) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_counts      = r_out_counts;
    assign o_position_ok = r_out_pos_ok;

endmodule
